>>> design/sfd_pkg.sv
// Shared types and constants for the sensor frame deframer.
package sfd_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned LenW    = 16;
    localparam int unsigned CountW  = 17;
    localparam int unsigned StatusW = 3;
    localparam int unsigned AddrW   = 5;
    localparam int unsigned DataW   = 32;

    // Result status codes
    localparam logic [StatusW-1:0] ST_HUNT_MISS = 3'd0;
    localparam logic [StatusW-1:0] ST_BUSY      = 3'd1;
    localparam logic [StatusW-1:0] ST_SUM_BAD   = 3'd2;
    localparam logic [StatusW-1:0] ST_LEN_BAD   = 3'd3;
    localparam logic [StatusW-1:0] ST_UNKNOWN   = 3'd4;
    localparam logic [StatusW-1:0] ST_GOOD      = 3'd5;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_HEADER    = 3'd0;
    localparam logic [2:0] REG_WHEEL_ID  = 3'd1;
    localparam logic [2:0] REG_IMU_ID    = 3'd2;
    localparam logic [2:0] REG_ROVER_ID  = 3'd3;
    localparam logic [2:0] REG_BASE_ID   = 3'd4;
    localparam logic [2:0] REG_WHEEL_LEN = 3'd5;
    localparam logic [2:0] REG_IMU_LEN   = 3'd6;

    // Register reset values
    localparam logic [ByteW-1:0] RST_HEADER    = 8'd170;
    localparam logic [ByteW-1:0] RST_WHEEL_ID  = 8'd1;
    localparam logic [ByteW-1:0] RST_IMU_ID    = 8'd2;
    localparam logic [ByteW-1:0] RST_ROVER_ID  = 8'd3;
    localparam logic [ByteW-1:0] RST_BASE_ID   = 8'd4;
    localparam logic [LenW-1:0]  RST_WHEEL_LEN = 16'd20;
    localparam logic [LenW-1:0]  RST_IMU_LEN   = 16'd44;

    // Byte positions of the id, the length bytes and the first payload byte within a frame
    localparam logic [CountW-1:0] POS_ID      = 17'd1;
    localparam logic [CountW-1:0] POS_LEN_LO  = 17'd2;
    localparam logic [CountW-1:0] POS_LEN_HI  = 17'd3;
    localparam logic [CountW-1:0] POS_PAYLOAD = 17'd4;

    typedef struct packed {
        logic [ByteW-1:0] header_byte;
        logic [ByteW-1:0] wheel_id;
        logic [ByteW-1:0] imu_id;
        logic [ByteW-1:0] rover_id;
        logic [ByteW-1:0] base_id;
        logic [LenW-1:0]  wheel_length;
        logic [LenW-1:0]  imu_length;
    } cfg_t;

    typedef struct packed {
        logic             payload_strobe;
        logic [ByteW-1:0] payload_byte;
        logic [ByteW-1:0] message_id;
        logic [StatusW-1:0] status;
    } result_t;

endpackage

>>> design/sensor_frame_deframer_top.sv
// Top level of the sensor frame deframer.
//
// Usage: received bytes enter on the s_ stream channel, one per transfer.
// Every accepted byte gives exactly one result transfer on the m_ channel:
// a status code (hunt miss, in progress, checksum bad, length mismatch,
// unknown id, frame good), the frame id on a good frame, and the byte itself
// with a strobe when it lies in the payload. Payload is forwarded, not held.
// Output: each result is registered in the output stage and waits there while m_tready is low.
// Throughput: one byte per cycle while s_tready is high; counter, checksum and verdict all settle
// in the single logic stage between the input and the result register.
// Stall: a two-entry output stage keeps s_tready high while one result waits;
// a second waiting result drops s_tready until m_tready drains the stage.
// Reset (aresetn low, synchronous): return to hunting for the header, clear
// checksum and length state, empty the output stage, and load the register
// defaults (header 0xAA, ids 1..4, lengths 20 and 44).
// Registers sit on the APB-style port at byte addresses 0x00 to 0x18;
// write them only while the stream is idle.
module sensor_frame_deframer_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] rx_byte
    // Result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [23:0]                m_tdata,   // [2:0] status, [10:3] message_id,
                                                  // [18:11] payload_byte, [23:19] zero
    output logic                       m_tuser,   // [0] payload_strobe
    // Configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sfd_pkg::AddrW-1:0]  paddr,
    input  logic [sfd_pkg::DataW-1:0]  pwdata,
    output logic [sfd_pkg::DataW-1:0]  prdata,
    output logic                       pready
);

    sfd_pkg::cfg_t    cfg;
    sfd_pkg::result_t parse_result;
    sfd_pkg::result_t out_result;
    logic             accept;

    // Registers never stall the bus
    assign pready = 1'b1;

    // A byte is consumed by the parser exactly when the stream transfer completes
    assign accept = s_tvalid && s_tready;

    sfd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    sfd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .rx_byte (s_tdata),
        .cfg     (cfg),
        .result  (parse_result)
    );

    // Park the result here so the receiver may stall without losing bytes
    sfd_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (parse_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    // Pack the result fields, lowest field first, zero fill to whole bytes
    assign m_tdata = {5'd0, out_result.payload_byte, out_result.message_id, out_result.status};
    assign m_tuser = out_result.payload_strobe;

    a_id_only_on_good: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != sfd_pkg::ST_GOOD |-> m_tdata[10:3] == 8'd0)
        else $error("message id shown on a frame that is not good");

    a_payload_zero_without_strobe: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[18:11] == 8'd0)
        else $error("payload byte shown without its strobe");

    a_stall_keeps_input_open: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !m_tvalid |-> s_tready)
        else $error("input blocked while the output stage is empty");

endmodule

>>> design/sfd_cfg_regs.sv
// Configuration register bank with APB-style access.
module sfd_cfg_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sfd_pkg::AddrW-1:0]    paddr,
    input  logic [sfd_pkg::DataW-1:0]    pwdata,
    output logic [sfd_pkg::DataW-1:0]    prdata,
    output sfd_pkg::cfg_t                cfg
);

    sfd_pkg::cfg_t cfg_reg;
    logic [2:0]    reg_index;
    logic          wr_en;

    assign reg_index = paddr[4:2];
    assign wr_en     = psel & penable & pwrite;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_byte  <= sfd_pkg::RST_HEADER;
            cfg_reg.wheel_id     <= sfd_pkg::RST_WHEEL_ID;
            cfg_reg.imu_id       <= sfd_pkg::RST_IMU_ID;
            cfg_reg.rover_id     <= sfd_pkg::RST_ROVER_ID;
            cfg_reg.base_id      <= sfd_pkg::RST_BASE_ID;
            cfg_reg.wheel_length <= sfd_pkg::RST_WHEEL_LEN;
            cfg_reg.imu_length   <= sfd_pkg::RST_IMU_LEN;
        end else if (wr_en) begin
            case (reg_index)
                sfd_pkg::REG_HEADER:    cfg_reg.header_byte  <= pwdata[7:0];
                sfd_pkg::REG_WHEEL_ID:  cfg_reg.wheel_id     <= pwdata[7:0];
                sfd_pkg::REG_IMU_ID:    cfg_reg.imu_id       <= pwdata[7:0];
                sfd_pkg::REG_ROVER_ID:  cfg_reg.rover_id     <= pwdata[7:0];
                sfd_pkg::REG_BASE_ID:   cfg_reg.base_id      <= pwdata[7:0];
                sfd_pkg::REG_WHEEL_LEN: cfg_reg.wheel_length <= pwdata[15:0];
                sfd_pkg::REG_IMU_LEN:   cfg_reg.imu_length   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            sfd_pkg::REG_HEADER:    prdata = {24'd0, cfg_reg.header_byte};
            sfd_pkg::REG_WHEEL_ID:  prdata = {24'd0, cfg_reg.wheel_id};
            sfd_pkg::REG_IMU_ID:    prdata = {24'd0, cfg_reg.imu_id};
            sfd_pkg::REG_ROVER_ID:  prdata = {24'd0, cfg_reg.rover_id};
            sfd_pkg::REG_BASE_ID:   prdata = {24'd0, cfg_reg.base_id};
            sfd_pkg::REG_WHEEL_LEN: prdata = {16'd0, cfg_reg.wheel_length};
            sfd_pkg::REG_IMU_LEN:   prdata = {16'd0, cfg_reg.imu_length};
            default:                prdata = '0;
        endcase
    end

endmodule

>>> design/sfd_parser.sv
// Frame parser: position counter, running checksum and frame verdict.
module sfd_parser (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       accept,
    input  logic [sfd_pkg::ByteW-1:0]  rx_byte,
    input  sfd_pkg::cfg_t              cfg,
    output sfd_pkg::result_t           result
);

    logic [sfd_pkg::CountW-1:0] count_reg, count_next;
    logic [sfd_pkg::ByteW-1:0]  sum_reg, sum_next;
    logic [sfd_pkg::ByteW-1:0]  id_reg, id_next;
    logic [sfd_pkg::ByteW-1:0]  len_lo_reg, len_lo_next;
    logic [sfd_pkg::LenW-1:0]   len_reg, len_next;

    logic [sfd_pkg::CountW-1:0] end_pos;
    logic                       in_body;
    logic                       frame_end;
    logic [sfd_pkg::StatusW-1:0] verdict;

    assign end_pos   = {1'b0, len_reg} + sfd_pkg::POS_PAYLOAD;
    assign in_body   = (count_reg >= sfd_pkg::POS_PAYLOAD);
    assign frame_end = in_body && (count_reg == end_pos);

    // Checksum first, then the id ladder in priority order
    always_comb begin
        if (sum_reg != rx_byte) begin
            verdict = sfd_pkg::ST_SUM_BAD;
        end else if (id_reg == cfg.wheel_id) begin
            verdict = (len_reg == cfg.wheel_length) ? sfd_pkg::ST_GOOD : sfd_pkg::ST_LEN_BAD;
        end else if (id_reg == cfg.imu_id) begin
            verdict = (len_reg == cfg.imu_length) ? sfd_pkg::ST_GOOD : sfd_pkg::ST_LEN_BAD;
        end else if (id_reg == cfg.rover_id || id_reg == cfg.base_id) begin
            verdict = sfd_pkg::ST_GOOD;
        end else begin
            verdict = sfd_pkg::ST_UNKNOWN;
        end
    end

    always_comb begin
        count_next  = count_reg;
        sum_next    = sum_reg;
        id_next     = id_reg;
        len_lo_next = len_lo_reg;
        len_next    = len_reg;
        result      = '0;
        result.status = sfd_pkg::ST_BUSY;
        if (count_reg == '0) begin
            if (rx_byte != cfg.header_byte) begin
                result.status = sfd_pkg::ST_HUNT_MISS;
            end else begin
                sum_next   = rx_byte;
                count_next = sfd_pkg::POS_ID;
            end
        end else if (frame_end) begin
            count_next    = '0;
            result.status = verdict;
            if (verdict == sfd_pkg::ST_GOOD) begin
                result.message_id = id_reg;
            end
        end else begin
            if (count_reg == sfd_pkg::POS_ID) begin
                id_next = rx_byte;
            end
            if (count_reg == sfd_pkg::POS_LEN_LO) begin
                len_lo_next = rx_byte;
            end
            if (count_reg == sfd_pkg::POS_LEN_HI) begin
                len_next = {rx_byte, len_lo_reg};
            end
            // Body bytes short of the checksum byte are payload
            if (in_body) begin
                result.payload_byte   = rx_byte;
                result.payload_strobe = 1'b1;
            end
            sum_next   = sum_reg + rx_byte;
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            sum_reg    <= '0;
            id_reg     <= '0;
            len_lo_reg <= '0;
            len_reg    <= '0;
        end else if (accept) begin
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            id_reg     <= id_next;
            len_lo_reg <= len_lo_next;
            len_reg    <= len_next;
        end
    end

    a_end_returns_to_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && frame_end |=> count_reg == '0)
        else $error("counter did not return to hunting after the checksum byte");

    a_miss_keeps_hunting: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && count_reg == '0 && rx_byte != cfg.header_byte |=> count_reg == '0)
        else $error("counter left hunting without a header byte");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= end_pos || count_reg <= sfd_pkg::POS_LEN_HI)
        else $error("counter ran past the end of the frame");

    a_strobe_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        result.payload_strobe |-> result.status == sfd_pkg::ST_BUSY)
        else $error("payload strobe raised outside a frame body");

endmodule

>>> design/sfd_out_skid.sv
// Two-entry output register with skid stage.
module sfd_out_skid (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  sfd_pkg::result_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sfd_pkg::result_t   out_data
);

    logic             main_valid_reg;
    sfd_pkg::result_t main_reg;
    logic             skid_valid_reg;
    sfd_pkg::result_t skid_reg;
    logic             push;
    logic             main_free;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign main_free = !main_valid_reg || out_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (main_free) begin
                if (skid_valid_reg) begin
                    main_valid_reg <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    main_valid_reg <= push;
                end
            end else if (push) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (main_free) begin
            main_reg <= skid_valid_reg ? skid_reg : in_data;
        end
        if (!main_free && push) begin
            skid_reg <= in_data;
        end
    end

endmodule
